[hdl/sitda_pkg.sv]
// Shared types and constants for the signed integer to decimal ASCII block.
// No dependencies; compile first.
`default_nettype none

package sitda_pkg;

  // One input item: integer and digits after the point.
  typedef struct packed {
    logic signed [31:0] value;
    logic [3:0]         decimals;
  } in_item_t;

  // One result item: a character and the end-of-text flag.
  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } out_item_t;

  localparam int unsigned NumDigits    = 10;
  localparam logic [3:0]  MaxDecimals  = 4'd9;
  localparam logic [7:0]  AsciiZero    = 8'h30;
  localparam logic [7:0]  AsciiMinus   = 8'h2D;
  localparam logic [7:0]  AsciiDot     = 8'h2E;
  // floor(x / 10) == (x * RecipTen) >> RecipShift for every 32-bit x
  localparam logic [31:0] RecipTen     = 32'hCCCC_CCCD;
  localparam int unsigned RecipShift   = 35;

endpackage

`default_nettype wire

[hdl/sitda_stream_if.sv]
// Valid/ready stream interface, payload type set per instance.
// Used with the item types of sitda_pkg.
`default_nettype none

interface sitda_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[hdl/signed_int_to_decimal_ascii.sv]
// Signed 32-bit integer to decimal ASCII text, one character per item; uses sitda_pkg.
// Digit extraction first (1..10 digits, one divide-by-ten step each), then one character
// per cycle while the sink is ready; 1 to 12 characters per input item.
// A new input item is taken only once the last character of the previous one is out,
// as the single shared divide-by-ten unit and the serial character output allow no overlap.
// Reset (rst_ni low, asynchronous): returns to idle, no item pending, ready high.
`default_nettype none

module signed_int_to_decimal_ascii (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  sitda_stream_if.sink     in_i,
  sitda_stream_if.source   out_o
);
  import sitda_pkg::*;

  typedef enum logic [1:0] {
    StIdle,
    StConv,
    StEmit
  } state_e;

  state_e      state_q, state_d;
  logic [31:0] mag_q, mag_d;
  logic        neg_q, neg_d;
  logic [3:0]  dec_q, dec_d;
  logic [3:0]  n_q, n_d;        // digits extracted so far
  logic [3:0]  pos_q, pos_d;    // digit position being emitted, counted from the right
  logic        sign_pend_q, sign_pend_d;
  logic        dot_pend_q, dot_pend_d;
  logic [3:0]  digs_q [NumDigits];

  // input side
  in_item_t    in_item;
  logic        in_fire;
  logic [31:0] raw;
  logic [3:0]  dec_sat;

  // shared divide-by-ten unit
  logic [63:0] prod;
  logic [31:0] quot;
  logic [31:0] quot_x10;
  logic [31:0] rem_full;
  logic [3:0]  rem;
  logic        conv_end;
  logic [3:0]  n_next;
  logic [3:0]  total;

  // output side
  out_item_t   out_item;
  logic        out_fire;
  logic [3:0]  cur_dig;

  assign in_item     = in_i.data;
  assign in_i.ready  = (state_q == StIdle);
  assign in_fire     = in_i.valid && in_i.ready;
  assign raw         = in_item.value;
  assign dec_sat     = (in_item.decimals > MaxDecimals) ? MaxDecimals : in_item.decimals;

  // Reciprocal multiply gives the quotient; the remainder needs only a shift-add
  // and a subtract.
  assign prod     = mag_q * RecipTen;
  assign quot     = prod[RecipShift +: 29] == '0 ? 32'd0 : {3'd0, prod[RecipShift +: 29]};
  assign quot_x10 = {quot[28:0], 3'd0} + {quot[30:0], 1'b0};
  assign rem_full = mag_q - quot_x10;
  assign rem      = rem_full[3:0];
  assign n_next   = n_q + 4'd1;
  assign conv_end = (quot == 32'd0) || (n_next == 4'(NumDigits));

  // Pad with zeros so a digit stands left of the point.
  always_comb begin
    total = n_next;
    if (dec_q != 4'd0 && total < dec_q + 4'd1) begin
      total = dec_q + 4'd1;
    end
  end

  // Character under presentation, straight from the emit registers.
  assign cur_dig = (pos_q < n_q) ? digs_q[pos_q] : 4'd0;

  always_comb begin
    if (sign_pend_q) begin
      out_item.character = AsciiMinus;
    end else if (dot_pend_q) begin
      out_item.character = AsciiDot;
    end else begin
      out_item.character = AsciiZero + {4'd0, cur_dig};
    end
    // the point never follows the units digit, so the units digit always ends the text
    out_item.last = !sign_pend_q && !dot_pend_q && (pos_q == 4'd0);
  end

  assign out_o.data  = out_item;
  assign out_o.valid = (state_q == StEmit);
  assign out_fire    = out_o.valid && out_o.ready;

  always_comb begin
    state_d     = state_q;
    mag_d       = mag_q;
    neg_d       = neg_q;
    dec_d       = dec_q;
    n_d         = n_q;
    pos_d       = pos_q;
    sign_pend_d = sign_pend_q;
    dot_pend_d  = dot_pend_q;
    case (state_q)
      StIdle: begin
        if (in_fire) begin
          neg_d   = raw[31];
          mag_d   = raw[31] ? (32'd0 - raw) : raw;  // unsigned, so the most negative value works
          dec_d   = dec_sat;
          n_d     = 4'd0;
          state_d = StConv;
        end
      end
      StConv: begin
        mag_d = quot;
        n_d   = n_next;
        if (conv_end) begin
          pos_d       = total - 4'd1;
          sign_pend_d = neg_q;
          dot_pend_d  = 1'b0;
          state_d     = StEmit;
        end
      end
      StEmit: begin
        if (out_fire) begin
          if (sign_pend_q) begin
            sign_pend_d = 1'b0;
          end else if (dot_pend_q) begin
            dot_pend_d = 1'b0;
            pos_d      = pos_q - 4'd1;
          end else if (dec_q != 4'd0 && pos_q == dec_q) begin
            dot_pend_d = 1'b1;
          end else if (pos_q == 4'd0) begin
            state_d = StIdle;
          end else begin
            pos_d = pos_q - 4'd1;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      sign_pend_q <= 1'b0;
      dot_pend_q  <= 1'b0;
      n_q         <= 4'd0;
      pos_q       <= 4'd0;
      mag_q       <= 32'd0;
      neg_q       <= 1'b0;
      dec_q       <= 4'd0;
    end else begin
      state_q     <= state_d;
      sign_pend_q <= sign_pend_d;
      dot_pend_q  <= dot_pend_d;
      n_q         <= n_d;
      pos_q       <= pos_d;
      mag_q       <= mag_d;
      neg_q       <= neg_d;
      dec_q       <= dec_d;
    end
  end

  // Digit store, least significant first; payload only, no reset.
  always_ff @(posedge clk_i) begin
    if (state_q == StConv) begin
      digs_q[n_q] <= rem;
    end
  end

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
// Self-checking testbench for signed_int_to_decimal_ascii: predicts the decimal text of each
// accepted integer and checks every emitted character and its last flag in order.
// Depends on sitda_pkg, sitda_stream_if and the block itself.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import sitda_pkg::*;

  // Expected text of every number that went in, oldest first, plus the mismatch tally.
  class fixed_point_text;
    out_item_t   pending_chars [$];
    int unsigned errors;
    int unsigned numbers_in;
    int unsigned chars_seen;

    function new();
      errors     = 0;
      numbers_in = 0;
      chars_seen = 0;
    endfunction

    // One line per mismatch; printing is capped so a broken build cannot flood the log.
    task report(input string msg);
      errors++;
      if (errors <= 40) begin
        $display("[%0t] MISMATCH: %s", $realtime, msg);
      end
    endtask

    // Render the number as text and queue its characters.
    function void add_number(input in_item_t num);
      logic [31:0] mag;
      logic [3:0]  dec;
      logic [3:0]  digs [NumDigits];
      int unsigned n;
      int unsigned total;
      int unsigned pos;
      out_item_t   text [$];
      out_item_t   ch;

      numbers_in++;
      mag = num.value;
      if (num.value[31]) begin
        mag = ~mag + 32'd1;   // 0x80000000 maps onto itself, read as unsigned
      end
      dec = (num.decimals > MaxDecimals) ? MaxDecimals : num.decimals;

      // digits, least significant first; zero still yields one digit
      n = 0;
      do begin
        digs[n] = 4'(mag % 32'd10);
        mag     = mag / 32'd10;
        n++;
      end while (mag != 0 && n < NumDigits);

      // pad with zeros so at least one digit sits left of the point
      total = n;
      if (dec != 0 && total < dec + 1) begin
        total = dec + 1;
      end

      ch.last = 1'b0;
      if (num.value[31]) begin
        ch.character = AsciiMinus;
        text.push_back(ch);
      end
      for (int k = total; k > 0; k--) begin
        pos          = k - 1;
        ch.character = AsciiZero + ((pos < n) ? 8'(digs[pos]) : 8'd0);
        text.push_back(ch);
        if (dec != 0 && pos == dec) begin
          ch.character = AsciiDot;
          text.push_back(ch);
        end
      end

      ch      = text[text.size() - 1];
      ch.last = 1'b1;
      text[text.size() - 1] = ch;
      foreach (text[i]) pending_chars.push_back(text[i]);
    endfunction

    // Compare one emitted character with the oldest expected one.
    task check_char(input out_item_t got);
      out_item_t want;

      chars_seen++;
      if (pending_chars.size() == 0) begin
        report($sformatf("character 0x%02h (last %0b) with no text pending",
                         got.character, got.last));
      end else begin
        want = pending_chars.pop_front();
        if (got.character !== want.character) begin
          report($sformatf("character 0x%02h, expected 0x%02h",
                           got.character, want.character));
        end
        if (got.last !== want.last) begin
          report($sformatf("last %0b on 0x%02h, expected %0b",
                           got.last, got.character, want.last));
        end
      end
    endtask

    function int unsigned pending();
      return pending_chars.size();
    endfunction
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // Idle bursts on both sides; switched off for the tail of the run.
  bit bursts_on;

  fixed_point_text text_board;

  sitda_stream_if #(.T(in_item_t))  in_if ();
  sitda_stream_if #(.T(out_item_t)) out_if ();

  signed_int_to_decimal_ascii i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if.sink),
    .out_o  (out_if.source)
  );

  // 8 ns period
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Sample both handshakes at the rising edge, before the block's own updates land.
  always @(posedge clk_i) begin
    if (rst_ni && text_board != null) begin
      if (in_if.valid && in_if.ready) begin
        text_board.add_number(in_if.data);
      end
      if (out_if.valid && out_if.ready) begin
        text_board.check_char(out_if.data);
      end
    end
  end

  // Receiver: ready drops for random bursts while bursts are enabled.
  initial begin
    int stall_left;

    out_if.ready = 1'b0;
    stall_left   = 0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else if (bursts_on && $urandom_range(0, 4) == 0) begin
        stall_left   = $urandom_range(1, 3) - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Offer one number; entered and left at a falling edge. Valid stays high between
  // back-to-back items, so it only ever gets one assignment per step.
  task send_number(input logic signed [31:0] value, input logic [3:0] decimals);
    in_item_t num;

    num.value    = value;
    num.decimals = decimals;
    if (bursts_on && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= num;
    do @(posedge clk_i); while (!in_if.ready);
    @(negedge clk_i);
  endtask

  // Mix of magnitudes: full range, short numbers, powers of ten and their neighbours,
  // and values close to either end of the range.
  function automatic logic signed [31:0] pick_value();
    logic [31:0] v;
    logic [31:0] p;

    case ($urandom_range(0, 5))
      0: v = $urandom;
      1: v = $urandom_range(0, 99);
      2: v = $urandom_range(0, 99999);
      3: begin
        p = 32'd1;
        repeat ($urandom_range(0, 9)) p = p * 32'd10;
        v = p + $urandom_range(0, 2) - 32'd1;
      end
      4: v = 32'h7FFF_FFFF - $urandom_range(0, 3);
      default: v = $urandom >> $urandom_range(0, 31);
    endcase
    if ($urandom_range(0, 1) == 1) begin
      v = ~v + 32'd1;
    end
    return v;
  endfunction

  // Stimulus
  initial begin
    logic [3:0] dec;

    text_board   = new();
    bursts_on    = 1'b1;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: zero, both range ends, padding, point placement, saturated decimals.
    send_number(32'sd0, 4'd0);
    send_number(32'sd0, 4'd9);
    send_number(32'sd0, 4'd15);
    send_number(32'sd5, 4'd2);
    send_number(-32'sd5, 4'd2);
    send_number(32'sd2147483647, 4'd0);
    send_number(32'sd2147483647, 4'd9);
    send_number(32'sh8000_0000, 4'd0);
    send_number(32'sh8000_0000, 4'd9);
    send_number(32'sh8000_0000, 4'd10);
    send_number(-32'sd1, 4'd0);
    send_number(32'sd1, 4'd1);
    send_number(32'sd9, 4'd1);
    send_number(32'sd10, 4'd1);
    send_number(-32'sd10, 4'd15);
    send_number(32'sd123, 4'd3);
    send_number(32'sd1234, 4'd3);
    send_number(-32'sd100, 4'd2);
    send_number(32'sd42, 4'd12);
    send_number(32'sd7, 4'd4);
    send_number(32'sd123456789, 4'd3);
    send_number(-32'sd987654321, 4'd5);
    send_number(32'sd1000000000, 4'd9);
    send_number(32'sd999999999, 4'd8);

    // Random part; halfway through the sender holds off until all text is out,
    // and the last stretch runs with both sides flat out.
    for (int i = 0; i < 420; i++) begin
      if (i == 200) begin
        in_if.valid <= 1'b0;
        while (text_board.pending() != 0) @(negedge clk_i);
      end
      bursts_on = (i < 360);
      dec = ($urandom_range(0, 5) == 0) ? 4'($urandom_range(10, 15))
                                        : 4'($urandom_range(0, 9));
      send_number(pick_value(), dec);
    end
    in_if.valid <= 1'b0;

    // drain, then leave room for anything stray
    while (text_board.pending() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);

    $display("Converted %0d numbers into %0d characters, signs, padding and saturated",
             text_board.numbers_in, text_board.chars_seen);
    $display("decimal counts included, with idle bursts on both sides; %0d mismatches.",
             text_board.errors);
    if (text_board.errors == 0 && text_board.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog, well beyond the slowest legal run.
  initial begin
    #5000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

`default_nettype wire
